[rtl/core/jsle_pkg.sv]
// Types, opcodes and status codes shared by the operand stack execution unit.
`default_nettype none
package jsle_pkg;

    typedef struct packed {
        logic [7:0]  cmd;
        logic [15:0] local_index;
        logic signed [15:0] immediate;
        logic signed [31:0] branch_offset;
        logic [31:0] instr_pc;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] top_value;
        logic [6:0]  stack_depth;
        logic        branch_taken;
        logic [31:0] branch_target;
    } t_out_word;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_UNDER  = 3'd1;
    localparam logic [2:0] ST_OVER   = 3'd2;
    localparam logic [2:0] ST_BADLOC = 3'd3;
    localparam logic [2:0] ST_UNSUP  = 3'd4;

    localparam logic [7:0] OP_NOP       = 8'h00;
    localparam logic [7:0] OP_ACONST    = 8'h01;
    localparam logic [7:0] OP_ICONST_M1 = 8'h02;
    localparam logic [7:0] OP_ICONST_5  = 8'h08;
    localparam logic [7:0] OP_LCONST_0  = 8'h09;
    localparam logic [7:0] OP_LCONST_1  = 8'h0A;
    localparam logic [7:0] OP_FCONST_0  = 8'h0B;
    localparam logic [7:0] OP_FCONST_1  = 8'h0C;
    localparam logic [7:0] OP_FCONST_2  = 8'h0D;
    localparam logic [7:0] OP_DCONST_0  = 8'h0E;
    localparam logic [7:0] OP_DCONST_1  = 8'h0F;
    localparam logic [7:0] OP_BIPUSH    = 8'h10;
    localparam logic [7:0] OP_SIPUSH    = 8'h11;
    localparam logic [7:0] OP_ILOAD     = 8'h15;
    localparam logic [7:0] OP_LLOAD     = 8'h16;
    localparam logic [7:0] OP_DLOAD     = 8'h18;
    localparam logic [7:0] OP_ALOAD     = 8'h19;
    localparam logic [7:0] OP_ILOAD_0   = 8'h1A;
    localparam logic [7:0] OP_ALOAD_3   = 8'h2D;
    localparam logic [7:0] OP_ISTORE    = 8'h36;
    localparam logic [7:0] OP_LSTORE    = 8'h37;
    localparam logic [7:0] OP_DSTORE    = 8'h39;
    localparam logic [7:0] OP_ASTORE    = 8'h3A;
    localparam logic [7:0] OP_ISTORE_0  = 8'h3B;
    localparam logic [7:0] OP_ASTORE_3  = 8'h4E;
    localparam logic [7:0] OP_POP       = 8'h57;
    localparam logic [7:0] OP_POP2      = 8'h58;
    localparam logic [7:0] OP_DUP       = 8'h59;
    localparam logic [7:0] OP_DUP_X1    = 8'h5A;
    localparam logic [7:0] OP_DUP_X2    = 8'h5B;
    localparam logic [7:0] OP_DUP2      = 8'h5C;
    localparam logic [7:0] OP_DUP2_X1   = 8'h5D;
    localparam logic [7:0] OP_DUP2_X2   = 8'h5E;
    localparam logic [7:0] OP_SWAP      = 8'h5F;
    localparam logic [7:0] OP_IADD      = 8'h60;
    localparam logic [7:0] OP_LADD      = 8'h61;
    localparam logic [7:0] OP_WIDE      = 8'hC4;
    localparam logic [7:0] OP_IFNULL    = 8'hC6;
    localparam logic [7:0] OP_IFNONNULL = 8'hC7;
    localparam logic [7:0] OP_GOTO_W    = 8'hC8;
    localparam logic [7:0] OP_JSR_W     = 8'hC9;

    localparam logic [31:0] FLOAT_ONE   = 32'h3F80_0000;
    localparam logic [31:0] FLOAT_TWO   = 32'h4000_0000;
    localparam logic [31:0] DOUBLE_ONE  = 32'h3FF0_0000;
    localparam logic [31:0] JSR_W_LEN   = 32'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EXEC,
        S_WR,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

[rtl/core/jsle_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module jsle_ram #(
    parameter int W = 32,
    parameter int D = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/core/jvm_stack_locals_executor.sv]
// Bytecode executor over an operand stack memory and a local slot memory.
//
//   channel   dir   handshake                  word
//   in        in    i_in_valid / o_in_ready    i_in_word  (t_in_word)
//   out       out   o_out_valid / i_out_ready  o_out_word (t_out_word)
//
// An item runs through one stack memory port: four top reads, then n writes,
// n = slots written (0 to 6; the larger of push count and local slots, 6 for dup2_x2).
// One item at a time; the result sits in an output register, and the next item
// is taken once that result is loaded there.
// Reset (synchronous, active low) empties the stack; memories are not cleared.
// A stalled output holds the sequencer in its last step until the word leaves.
`default_nettype none
module jvm_stack_locals_executor #(
    parameter int STACK_DEPTH = 64,
    parameter int LOCAL_COUNT = 256
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire jsle_pkg::t_in_word  i_in_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output jsle_pkg::t_out_word      o_out_word
);
    import jsle_pkg::*;

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int LAW = $clog2(LOCAL_COUNT);
    localparam logic [SPW:0] STK_MAX = (SPW + 1)'(STACK_DEPTH);
    localparam logic [16:0]  LOC_MAX = 17'(LOCAL_COUNT);

    t_state         r_state, n_state;
    t_in_word       r_in;
    logic [SPW-1:0] r_sp;
    logic [2:0]     r_cnt;
    logic [31:0]    r_t [4];
    logic [31:0]    r_l [2];
    logic [31:0]    r_v [6];
    logic [2:0]     r_status;
    logic [SPW-1:0] r_base;
    logic [2:0]     r_npush;
    logic [2:0]     r_need;
    logic [1:0]     r_lwrite;
    logic [15:0]    r_lidx;
    logic [2:0]     r_nwr;
    logic           r_taken;
    logic [31:0]    r_target;
    logic           r_out_valid;
    t_out_word      r_out;

    logic [2:0]  d_need, d_npush;
    logic [1:0]  d_lslots, d_lwrite;
    logic [15:0] d_lidx;
    logic        d_known, d_taken;
    logic [31:0] d_v [6];
    logic [4:0]  d_k;
    logic [63:0] d_lsum;
    logic [2:0]  d_status;
    logic [SPW:0] d_spx;

    logic              stk_we, loc_we;
    logic [SAW-1:0]    stk_waddr, stk_raddr;
    logic [LAW-1:0]    loc_waddr, loc_raddr;
    logic [31:0]       stk_wdata, loc_wdata, stk_rdata, loc_rdata;
    logic [SPW-1:0]    stk_rsp, stk_wsp;
    logic [16:0]       loc_ridx, loc_widx;
    logic [31:0]       top;

    jsle_ram #(.W(32), .D(STACK_DEPTH)) u_stack (
        .i_clk  (i_clk),
        .i_we   (stk_we),
        .i_waddr(stk_waddr),
        .i_wdata(stk_wdata),
        .i_raddr(stk_raddr),
        .o_rdata(stk_rdata)
    );

    jsle_ram #(.W(32), .D(LOCAL_COUNT)) u_locals (
        .i_clk  (i_clk),
        .i_we   (loc_we),
        .i_waddr(loc_waddr),
        .i_wdata(loc_wdata),
        .i_raddr(loc_raddr),
        .o_rdata(loc_rdata)
    );

    // decode
    always_comb begin
        d_need   = '0;
        d_npush  = '0;
        d_lslots = '0;
        d_lwrite = '0;
        d_lidx   = '0;
        d_known  = 1'b1;
        d_taken  = 1'b0;
        d_k      = '0;
        d_lsum   = {r_t[3], r_t[2]} + {r_t[1], r_t[0]};
        for (int i = 0; i < 6; i++) begin
            d_v[i] = '0;
        end
        if (r_in.cmd >= OP_ILOAD && r_in.cmd <= OP_ALOAD_3) begin
            if (r_in.cmd <= OP_ALOAD) begin
                d_lidx   = r_in.local_index;
                d_lslots = (r_in.cmd == OP_LLOAD || r_in.cmd == OP_DLOAD) ? 2'd2 : 2'd1;
            end else begin
                d_k      = 5'(r_in.cmd - OP_ILOAD_0);
                d_lidx   = {14'd0, d_k[1:0]};
                d_lslots = d_k[2] ? 2'd2 : 2'd1;
            end
            d_npush = {1'b0, d_lslots};
            d_v[0]  = r_l[0];
            d_v[1]  = r_l[1];
        end else if (r_in.cmd >= OP_ISTORE && r_in.cmd <= OP_ASTORE_3) begin
            if (r_in.cmd <= OP_ASTORE) begin
                d_lidx   = r_in.local_index;
                d_lslots = (r_in.cmd == OP_LSTORE || r_in.cmd == OP_DSTORE) ? 2'd2 : 2'd1;
            end else begin
                d_k      = 5'(r_in.cmd - OP_ISTORE_0);
                d_lidx   = {14'd0, d_k[1:0]};
                d_lslots = d_k[2] ? 2'd2 : 2'd1;
            end
            d_need   = {1'b0, d_lslots};
            d_lwrite = d_lslots;
        end else begin
            unique case (r_in.cmd) inside
                OP_NOP, OP_WIDE: begin
                end
                OP_ACONST, OP_FCONST_0: begin
                    d_npush = 3'd1;
                end
                [OP_ICONST_M1:OP_ICONST_5]: begin
                    d_npush = 3'd1;
                    d_v[0]  = 32'(r_in.cmd) - 32'(OP_ICONST_M1) - 32'd1;
                end
                OP_LCONST_0, OP_LCONST_1: begin
                    d_npush = 3'd2;
                    d_v[1]  = 32'(r_in.cmd - OP_LCONST_0);
                end
                OP_FCONST_1: begin
                    d_npush = 3'd1;
                    d_v[0]  = FLOAT_ONE;
                end
                OP_FCONST_2: begin
                    d_npush = 3'd1;
                    d_v[0]  = FLOAT_TWO;
                end
                OP_DCONST_0: begin
                    d_npush = 3'd2;
                end
                OP_DCONST_1: begin
                    d_npush = 3'd2;
                    d_v[0]  = DOUBLE_ONE;
                end
                OP_BIPUSH: begin
                    d_npush = 3'd1;
                    d_v[0]  = {{24{r_in.immediate[7]}}, r_in.immediate[7:0]};
                end
                OP_SIPUSH: begin
                    d_npush = 3'd1;
                    d_v[0]  = {{16{r_in.immediate[15]}}, r_in.immediate};
                end
                OP_POP: begin
                    d_need = 3'd1;
                end
                OP_POP2: begin
                    d_need = 3'd2;
                end
                OP_DUP: begin
                    d_need  = 3'd1;
                    d_npush = 3'd2;
                    d_v[0]  = r_t[0];
                    d_v[1]  = r_t[0];
                end
                OP_DUP_X1: begin
                    d_need  = 3'd2;
                    d_npush = 3'd3;
                    d_v[0]  = r_t[0];
                    d_v[1]  = r_t[1];
                    d_v[2]  = r_t[0];
                end
                OP_DUP_X2: begin
                    d_need  = 3'd3;
                    d_npush = 3'd4;
                    d_v[0]  = r_t[0];
                    d_v[1]  = r_t[2];
                    d_v[2]  = r_t[1];
                    d_v[3]  = r_t[0];
                end
                OP_DUP2: begin
                    d_need  = 3'd2;
                    d_npush = 3'd4;
                    d_v[0]  = r_t[1];
                    d_v[1]  = r_t[0];
                    d_v[2]  = r_t[1];
                    d_v[3]  = r_t[0];
                end
                OP_DUP2_X1: begin
                    d_need  = 3'd3;
                    d_npush = 3'd5;
                    d_v[0]  = r_t[1];
                    d_v[1]  = r_t[0];
                    d_v[2]  = r_t[2];
                    d_v[3]  = r_t[1];
                    d_v[4]  = r_t[0];
                end
                OP_DUP2_X2: begin
                    d_need  = 3'd4;
                    d_npush = 3'd6;
                    d_v[0]  = r_t[1];
                    d_v[1]  = r_t[0];
                    d_v[2]  = r_t[3];
                    d_v[3]  = r_t[2];
                    d_v[4]  = r_t[1];
                    d_v[5]  = r_t[0];
                end
                OP_SWAP: begin
                    d_need  = 3'd2;
                    d_npush = 3'd2;
                    d_v[0]  = r_t[0];
                    d_v[1]  = r_t[1];
                end
                OP_IADD: begin
                    d_need  = 3'd2;
                    d_npush = 3'd1;
                    d_v[0]  = r_t[1] + r_t[0];
                end
                OP_LADD: begin
                    d_need  = 3'd4;
                    d_npush = 3'd2;
                    d_v[0]  = d_lsum[63:32];
                    d_v[1]  = d_lsum[31:0];
                end
                OP_IFNULL: begin
                    d_need  = 3'd1;
                    d_taken = (r_t[0] == 32'd0);
                end
                OP_IFNONNULL: begin
                    d_need  = 3'd1;
                    d_taken = (r_t[0] != 32'd0);
                end
                OP_GOTO_W: begin
                    d_taken = 1'b1;
                end
                OP_JSR_W: begin
                    d_npush = 3'd1;
                    d_v[0]  = r_in.instr_pc + JSR_W_LEN;
                    d_taken = 1'b1;
                end
                default: begin
                    d_known = 1'b0;
                end
            endcase
        end

        d_spx = {1'b0, r_sp} + (SPW + 1)'(d_npush);
        if (!d_known) begin
            d_status = ST_UNSUP;
        end else if (r_sp < SPW'(d_need)) begin
            d_status = ST_UNDER;
        end else if (d_spx > STK_MAX + (SPW + 1)'(d_need)) begin
            d_status = ST_OVER;
        end else if (d_lslots != 2'd0 && {1'b0, d_lidx} + 17'(d_lslots) > LOC_MAX) begin
            d_status = ST_BADLOC;
        end else begin
            d_status = ST_OK;
        end
    end

    // memory ports
    always_comb begin
        stk_rsp   = r_sp - SPW'(1) - SPW'(r_cnt);
        stk_raddr = stk_rsp[SAW-1:0];
        loc_ridx  = {1'b0, r_lidx} + 17'(r_cnt[0]);
        loc_raddr = loc_ridx[LAW-1:0];
        stk_wsp   = r_base + SPW'(r_cnt);
        stk_waddr = stk_wsp[SAW-1:0];
        stk_we    = (r_state == S_WR) && (r_cnt < r_npush);
        stk_wdata = (r_cnt < 3'd6) ? r_v[r_cnt] : 32'd0;
        loc_widx  = {1'b0, r_lidx} + 17'(r_cnt);
        loc_waddr = loc_widx[LAW-1:0];
        loc_we    = (r_state == S_WR) && (r_cnt < {1'b0, r_lwrite});
        loc_wdata = (r_lwrite == 2'd2 && r_cnt == 3'd0) ? r_t[1] : r_t[0];
        if (r_npush != 3'd0) begin
            top = r_v[r_npush - 3'd1];
        end else if (r_sp != '0) begin
            top = r_t[r_need[1:0]];
        end else begin
            top = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (r_cnt == 3'd4) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = (d_status == ST_OK && (d_npush != 3'd0 || d_lwrite != 2'd0))
                          ? S_WR : S_DONE;
            end
            S_WR: begin
                if (r_cnt + 3'd1 >= r_nwr) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp        <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (i_in_valid) begin
                        r_in <= i_in_word;
                    end
                end
                S_RD: begin
                    r_cnt <= (r_cnt == 3'd4) ? 3'd0 : r_cnt + 3'd1;
                    if (r_cnt == 3'd0) begin
                        r_lidx <= d_lidx;
                    end
                    if (r_cnt != 3'd0) begin
                        r_t[r_cnt[1:0] - 2'd1] <=
                            (SPW'(r_cnt - 3'd1) < r_sp) ? stk_rdata : 32'd0;
                    end
                    if (r_cnt == 3'd3) begin
                        r_l[0] <= loc_rdata;
                    end
                    if (r_cnt == 3'd2) begin
                        r_l[1] <= loc_rdata;
                    end
                end
                S_EXEC: begin
                    r_cnt    <= '0;
                    r_status <= d_status;
                    r_v      <= d_v;
                    r_lidx   <= d_lidx;
                    r_target <= r_in.instr_pc + 32'(r_in.branch_offset);
                    if (d_status == ST_OK) begin
                        r_base   <= r_sp - SPW'(d_need);
                        r_sp     <= r_sp - SPW'(d_need) + SPW'(d_npush);
                        r_npush  <= d_npush;
                        r_need   <= d_need;
                        r_lwrite <= d_lwrite;
                        r_nwr    <= (d_npush > {1'b0, d_lwrite}) ? d_npush : {1'b0, d_lwrite};
                        r_taken  <= d_taken;
                    end else begin
                        r_base   <= r_sp;
                        r_npush  <= '0;
                        r_need   <= '0;
                        r_lwrite <= '0;
                        r_nwr    <= '0;
                        r_taken  <= 1'b0;
                    end
                end
                S_WR: begin
                    r_cnt <= r_cnt + 3'd1;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid         <= 1'b1;
                        r_out.status        <= r_status;
                        r_out.top_value     <= top;
                        r_out.stack_depth   <= 7'(r_sp);
                        r_out.branch_taken  <= r_taken;
                        r_out.branch_target <= r_taken ? r_target : 32'd0;
                    end else begin
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_err_no_branch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status != ST_OK) |-> !o_out_word.branch_taken)
        else $error("branch taken on faulted word");

    a_err_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> (r_status == ST_OK))
        else $error("memory write after fault");

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_RD))
        else $error("accepted word did not start reads");

endmodule
`default_nettype wire
